// ===== design/ltpc_pkg.sv =====
// Shared types and constants of the level trigger with pre-trigger capture.
package ltpc_pkg;

    localparam int PRE_MAX_DEF = 32;

    localparam int SAMPLE_W   = 16;
    localparam int THRESH_W   = 32;
    localparam int PRE_LEN_W  = 6;
    localparam int POST_LEN_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_LEN     = 2'd2;

    localparam logic [THRESH_W-1:0]   THRESHOLD_SQ_RST = 32'd0;
    localparam logic [PRE_LEN_W-1:0]  PRE_LEN_RST      = 6'd16;
    localparam logic [POST_LEN_W-1:0] POST_LEN_RST     = 16'd16;

    // Q sits in the upper half, I in the lower half of the packed word.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_q;
        logic signed [SAMPLE_W-1:0] sample_i;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_i;
        logic signed [SAMPLE_W-1:0] out_q;
        logic                       capture_last;
    } t_out_item;

    typedef struct packed {
        logic wr_en;     // store the current sample, advance write pointer
        logic rd_start;  // load read pointer with the oldest pre-trigger slot
        logic rd_en;     // read one slot, advance read pointer
    } t_ring_ctl;

endpackage

// ===== design/ltpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ltpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ltpc_ring.sv =====
// Pre-trigger history ring: RAM, write and read pointers, per-slot valid bits.
module ltpc_ring #(
    parameter int PRE_MAX = ltpc_pkg::PRE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ltpc_pkg::t_ring_ctl           i_ctl,
    input  ltpc_pkg::t_in_item            i_wr_data,
    input  logic [ltpc_pkg::PRE_LEN_W-1:0] i_npre,
    output ltpc_pkg::t_in_item            o_rd_data
);
    import ltpc_pkg::*;

    localparam int AW = (PRE_MAX > 1) ? $clog2(PRE_MAX) : 1;
    localparam int DW = $bits(t_in_item);

    logic [AW-1:0]      r_wr_pos;
    logic [AW-1:0]      r_rd_pos;
    logic [PRE_MAX-1:0] r_vld;
    logic               r_rd_ok;
    logic [DW-1:0]      w_ram_q;
    logic [AW:0]        w_start_sum;
    logic [AW-1:0]      w_start;

    // Oldest wanted slot: write pointer minus npre, modulo the ring depth.
    assign w_start_sum = {1'b0, r_wr_pos} + (AW+1)'(PRE_MAX) - (AW+1)'(i_npre);
    assign w_start     = (w_start_sum >= (AW+1)'(PRE_MAX))
                       ? AW'(w_start_sum - (AW+1)'(PRE_MAX))
                       : w_start_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_vld    <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[r_wr_pos] <= 1'b1;
                r_wr_pos <= (r_wr_pos == AW'(PRE_MAX - 1)) ? '0 : r_wr_pos + 1'b1;
            end
            if (i_ctl.rd_start) begin
                r_rd_pos <= w_start;
            end else if (i_ctl.rd_en) begin
                r_rd_ok  <= r_vld[r_rd_pos];
                r_rd_pos <= (r_rd_pos == AW'(PRE_MAX - 1)) ? '0 : r_rd_pos + 1'b1;
            end
        end
    end

    ltpc_ram #(
        .WIDTH (DW),
        .DEPTH (PRE_MAX),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (r_wr_pos),
        .i_wdata (i_wr_data),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_rd_pos),
        .o_rdata (w_ram_q)
    );

    // A slot never written reads as a zero sample.
    assign o_rd_data = r_rd_ok ? t_in_item'(w_ram_q) : '0;

endmodule

// ===== design/level_trigger_pretrigger_capture.sv =====
// Top level: level trigger on squared I/Q magnitude with pre-trigger capture.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (sample_i, sample_q)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (out_i, out_q, last)
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// Rate: one item per cycle while idle, or while capturing and the output takes
// items. A trigger item with npre pre-trigger samples is held through a start step
// that loads the read pointer, npre reads through the registered RAM output, then
// the trigger sample (none when post_len is zero); npre zero skips start and reads.
// Reset: synchronous, active low; per-slot valid bits make the ring read as zeros.
// Stalls: a stalled output holds the sequencer and, once it needs to emit, the input.
module level_trigger_pretrigger_capture #(
    parameter int PRE_MAX = ltpc_pkg::PRE_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ltpc_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ltpc_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_we,
    input  logic [ltpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ltpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ltpc_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,   // decide on the held item: skip, capture step, or trigger
        ST_PRE,   // stream pre-trigger samples out of the ring
        ST_TRIG   // emit the triggering sample
    } t_state;

    // Configuration
    logic [THRESH_W-1:0]   r_threshold_sq;
    logic [PRE_LEN_W-1:0]  r_pre_len;
    logic [POST_LEN_W-1:0] r_post_len;

    // Held item and its squares, computed on the way in
    logic                  r_hv;
    t_in_item              r_hold;
    logic [30:0]           r_sq_i;
    logic [30:0]           r_sq_q;

    // Sequencer state
    t_state                r_state;
    logic                  r_capturing;
    logic [POST_LEN_W-1:0] r_remaining;
    logic [PRE_LEN_W-1:0]  r_pre_left;
    logic                  r_pend;

    // Output register
    logic                  r_out_valid;
    t_out_item             r_out;

    logic signed [31:0]    w_prod_i;
    logic signed [31:0]    w_prod_q;
    logic [31:0]           w_mag;
    logic                  w_trig;
    logic [PRE_LEN_W-1:0]  w_npre;
    logic [POST_LEN_W-1:0] w_rem_dec;
    logic                  w_out_free;
    logic                  w_done;
    logic                  w_emit;
    t_out_item             w_emit_item;
    t_ring_ctl             w_ctl;
    t_in_item              w_ring_q;

    assign w_prod_i   = i_in_item.sample_i * i_in_item.sample_i;
    assign w_prod_q   = i_in_item.sample_q * i_in_item.sample_q;
    assign w_mag      = 32'(r_sq_i) + 32'(r_sq_q);
    assign w_trig     = w_mag > r_threshold_sq;
    assign w_npre     = (r_pre_len > PRE_LEN_W'(PRE_MAX)) ? PRE_LEN_W'(PRE_MAX) : r_pre_len;
    assign w_rem_dec  = (r_remaining != '0) ? r_remaining - 1'b1 : '0;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_hv || w_done;

    // Decide what the held item does this cycle.
    always_comb begin
        w_ctl       = '0;
        w_done      = 1'b0;
        w_emit      = 1'b0;
        w_emit_item = '0;
        unique case (r_state)
            ST_RUN: begin
                if (r_hv) begin
                    if (r_capturing) begin
                        // Mid-capture: one sample out per item.
                        if (w_out_free) begin
                            w_emit                   = 1'b1;
                            w_emit_item.out_i        = r_hold.sample_i;
                            w_emit_item.out_q        = r_hold.sample_q;
                            w_emit_item.capture_last = (w_rem_dec == '0);
                            w_ctl.wr_en              = 1'b1;
                            w_done                   = 1'b1;
                        end
                    end else if (!w_trig) begin
                        w_ctl.wr_en = 1'b1;
                        w_done      = 1'b1;
                    end else if (w_npre != '0) begin
                        w_ctl.rd_start = 1'b1;
                    end else if (r_post_len == '0) begin
                        // Empty window: nothing to send.
                        w_ctl.wr_en = 1'b1;
                        w_done      = 1'b1;
                    end
                end
            end
            ST_PRE: begin
                if (r_pend && w_out_free) begin
                    w_emit                   = 1'b1;
                    w_emit_item.out_i        = w_ring_q.sample_i;
                    w_emit_item.out_q        = w_ring_q.sample_q;
                    w_emit_item.capture_last = (r_post_len == '0) && (r_pre_left == '0);
                    if (r_pre_left == '0 && r_post_len == '0) begin
                        w_ctl.wr_en = 1'b1;
                        w_done      = 1'b1;
                    end
                end
                // Issue the next read when the RAM output is free or drains now.
                if (r_pre_left != '0 && (!r_pend || w_out_free)) begin
                    w_ctl.rd_en = 1'b1;
                end
            end
            ST_TRIG: begin
                if (w_out_free) begin
                    w_emit                   = 1'b1;
                    w_emit_item.out_i        = r_hold.sample_i;
                    w_emit_item.out_q        = r_hold.sample_q;
                    w_emit_item.capture_last = (r_post_len == POST_LEN_W'(1));
                    w_ctl.wr_en              = 1'b1;
                    w_done                   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_sq <= THRESHOLD_SQ_RST;
            r_pre_len      <= PRE_LEN_RST;
            r_post_len     <= POST_LEN_RST;
            r_hv           <= 1'b0;
            r_state        <= ST_RUN;
            r_capturing    <= 1'b0;
            r_remaining    <= '0;
            r_pre_left     <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD_SQ: r_threshold_sq <= i_cfg_data;
                    CFG_PRE_LEN:      r_pre_len      <= i_cfg_data[PRE_LEN_W-1:0];
                    CFG_POST_LEN:     r_post_len     <= i_cfg_data[POST_LEN_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Take a new item whenever the holding stage frees up.
            if (o_in_ready) begin
                r_hv <= i_in_valid;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_emit_item;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_RUN: begin
                    if (r_hv && r_capturing) begin
                        if (w_out_free) begin
                            r_remaining <= w_rem_dec;
                            if (w_rem_dec == '0) begin
                                r_capturing <= 1'b0;
                            end
                        end
                    end else if (r_hv && w_trig) begin
                        if (w_npre != '0) begin
                            r_state    <= ST_PRE;
                            r_pre_left <= w_npre;
                            r_pend     <= 1'b0;
                        end else if (r_post_len != '0) begin
                            r_state <= ST_TRIG;
                        end else begin
                            r_remaining <= '0;
                        end
                    end
                end
                ST_PRE: begin
                    if (w_ctl.rd_en) begin
                        r_pre_left <= r_pre_left - 1'b1;
                        r_pend     <= 1'b1;
                    end else if (r_pend && w_out_free) begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && w_out_free && r_pre_left == '0) begin
                        if (r_post_len == '0) begin
                            r_state     <= ST_RUN;
                            r_remaining <= '0;
                        end else begin
                            r_state <= ST_TRIG;
                        end
                    end
                end
                ST_TRIG: begin
                    if (w_out_free) begin
                        r_remaining <= r_post_len - 1'b1;
                        r_capturing <= (r_post_len != POST_LEN_W'(1));
                        r_state     <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_hold <= i_in_item;
            r_sq_i <= w_prod_i[30:0];
            r_sq_q <= w_prod_q[30:0];
        end
    end

    ltpc_ring #(
        .PRE_MAX (PRE_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_data (r_hold),
        .i_npre    (w_npre),
        .o_rd_data (w_ring_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== tb/level_trigger_pretrigger_capture_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the level trigger with pre-trigger capture.
module level_trigger_pretrigger_capture_test;
    import ltpc_pkg::*;

    localparam int PRE_N       = PRE_MAX_DEF;
    localparam int SLOT_W      = $clog2(PRE_N);
    // Longer than the worst trigger, which replays the full ring; gives a margin on top.
    localparam int DRAIN       = PRE_N + 8;
    localparam int WATCH_MAX   = 4000;
    localparam int HOLD_LEN    = 300;
    localparam int GAP_MAX     = 60;
    localparam int PHASE_N     = 6;
    localparam int PHASE_ITEMS = 19;
    localparam int SHOW_MAX    = 10;

    typedef enum {ROW_CFG, ROW_SAMPLE} t_row_kind;
    typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    // One line of the directed table: a register write or a sample. For a sample,
    // n_out >= 0 gives the typed result count and first holds the first result.
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              smp;
        int                    n_out;
        t_out_item             first;
    } t_stim_row;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item  = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    // Local copy of the block: history ring, capture state and register mirror.
    t_in_item              hist [PRE_N];
    logic [SLOT_W-1:0]     hist_wr   = '0;
    logic                  cap_on    = 1'b0;
    logic [POST_LEN_W-1:0] post_left = '0;
    logic [THRESH_W-1:0]   thr_sq    = THRESHOLD_SQ_RST;
    logic [PRE_LEN_W-1:0]  pre_n     = PRE_LEN_RST;
    logic [POST_LEN_W-1:0] post_n    = POST_LEN_RST;

    // Captured samples still owed by the block, oldest first.
    t_out_item capture_q [$];

    int fault_cnt    = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cyc    = 0;

    level_trigger_pretrigger_capture #(
        .PRE_MAX(PRE_N)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_in_item mk_smp(int si, int sq);
        t_in_item s;
        s.sample_i = 16'(si);
        s.sample_q = 16'(sq);
        return s;
    endfunction

    function automatic t_out_item mk_res(int ri, int rq, bit last);
        t_out_item r;
        r.out_i        = 16'(ri);
        r.out_q        = 16'(rq);
        r.capture_last = last;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.smp   = '0;
        r.n_out = -1;
        r.first = '0;
        return r;
    endfunction

    function automatic t_stim_row smp_row(int si, int sq, int n, t_out_item first);
        t_stim_row r;
        r.kind  = ROW_SAMPLE;
        r.idx   = '0;
        r.data  = '0;
        r.smp   = mk_smp(si, sq);
        r.n_out = n;
        r.first = first;
        return r;
    endfunction

    // Append one owed item at the tail of the queue.
    function automatic void owe_item(input t_out_item r);
        capture_q = {capture_q, r};
    endfunction

    task automatic flag_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= SHOW_MAX) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Advance the local copy by one accepted sample and queue what it emits.
    task automatic step_trigger(input t_in_item s);
        int                si;
        int                sq;
        int                npre;
        logic [31:0]       mag;
        logic [SLOT_W-1:0] slot;
        si  = $signed(s.sample_i);
        sq  = $signed(s.sample_q);
        mag = 32'(si * si) + 32'(sq * sq);
        if (!cap_on) begin
            if (mag > thr_sq) begin
                // Clamp an oversized pre length to the ring depth.
                npre = (pre_n > PRE_N) ? PRE_N : int'(pre_n);
                // Replay the ring oldest first; with no post part the last
                // pre sample closes the window.
                for (int k = 0; k < npre; k++) begin
                    slot = SLOT_W'(int'(hist_wr) - npre + k);
                    owe_item(mk_res($signed(hist[slot].sample_i),
                                    $signed(hist[slot].sample_q),
                                    post_n == 0 && k == npre - 1));
                end
                if (post_n != 0) begin
                    post_left = post_n - 1'b1;
                    if (post_left == 0) begin
                        owe_item(mk_res(si, sq, 1'b1));
                    end else begin
                        owe_item(mk_res(si, sq, 1'b0));
                        cap_on = 1'b1;
                    end
                end else begin
                    post_left = '0;
                end
            end
        end else begin
            // No trigger test while capturing; just count down the window.
            if (post_left > 0) post_left = post_left - 1'b1;
            if (post_left == 0) begin
                owe_item(mk_res(si, sq, 1'b1));
                cap_on = 1'b0;
            end else begin
                owe_item(mk_res(si, sq, 1'b0));
            end
        end
        // Every sample lands in the ring, the trigger sample after the replay.
        hist[hist_wr] = s;
        hist_wr       = hist_wr + 1'b1;
    endtask

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_sample(input t_in_item s, input int n_ref,
                               input t_out_item first_ref);
        int gap;
        int start;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < tx_idle_pct) gap++;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= s;
        do @(posedge clk); while (!o_in_ready);
        start = capture_q.size();
        step_trigger(s);
        // Cross-check the typed rows of the directed table.
        if (n_ref >= 0) begin
            if (capture_q.size() - start != n_ref) begin
                flag_fault($sformatf("sample %0d/%0d: count exp %0d act %0d",
                                     $signed(s.sample_i), $signed(s.sample_q),
                                     n_ref, capture_q.size() - start));
            end else if (n_ref > 0 && capture_q[start] != first_ref) begin
                flag_fault($sformatf("sample %0d/%0d: first exp %0d/%0d/%0b act %0d/%0d/%0b",
                                     $signed(s.sample_i), $signed(s.sample_q),
                                     $signed(first_ref.out_i),
                                     $signed(first_ref.out_q),
                                     first_ref.capture_last,
                                     $signed(capture_q[start].out_i),
                                     $signed(capture_q[start].out_q),
                                     capture_q[start].capture_last));
            end
        end
    endtask

    // Drop valid, wait for every owed item and let the block finish its work.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (capture_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD_SQ: thr_sq = data[THRESH_W-1:0];
            CFG_PRE_LEN:      pre_n  = data[PRE_LEN_W-1:0];
            CFG_POST_LEN:     post_n = data[POST_LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver: random stalls per phase, plus one long hold-off on request.
    always @(negedge clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each delivered item with the oldest owed one.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (capture_q.size() == 0) begin
                flag_fault($sformatf("unexpected item %0d/%0d/%0b",
                                     $signed(o_out_item.out_i),
                                     $signed(o_out_item.out_q),
                                     o_out_item.capture_last));
            end else begin
                want = capture_q.pop_front();
                if (o_out_item.out_i !== want.out_i ||
                    o_out_item.out_q !== want.out_q ||
                    o_out_item.capture_last !== want.capture_last) begin
                    flag_fault($sformatf("item exp %0d/%0d/%0b act %0d/%0d/%0b",
                                         $signed(want.out_i), $signed(want.out_q),
                                         want.capture_last,
                                         $signed(o_out_item.out_i),
                                         $signed(o_out_item.out_q),
                                         o_out_item.capture_last));
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cyc = 0;
            end else begin
                quiet_cyc++;
                if (quiet_cyc >= WATCH_MAX) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_stim_row  dir_tab [$];
        t_idle_mode mode;
        t_in_item   s;
        for (int k = 0; k < PRE_N; k++) hist[k] = '0;

        // Directed rows: reset values first, then the extremes and corner cases.
        dir_tab = '{
            // zero magnitude against a zero threshold: strict compare, no trigger
            smp_row(0, 0, 0, mk_res(0, 0, 0)),
            cfg_row(CFG_POST_LEN, 1),
            // first trigger replays a history mostly never written: zeros
            smp_row(1, 0, 17, mk_res(0, 0, 0)),
            cfg_row(CFG_THRESHOLD_SQ, 32'h8000_0000),
            // largest magnitude equals the largest threshold: no trigger
            smp_row(-32768, -32768, 0, mk_res(0, 0, 0)),
            cfg_row(CFG_THRESHOLD_SQ, 32'h7FFF_FFFF),
            smp_row(32767, 32767, 0, mk_res(0, 0, 0)),
            smp_row(-32768, -32768, 17, mk_res(0, 0, 0)),
            // pre length above the ring depth, zero post length
            cfg_row(CFG_PRE_LEN, 63),
            cfg_row(CFG_POST_LEN, 0),
            cfg_row(CFG_THRESHOLD_SQ, 0),
            smp_row(5, -7, 32, mk_res(0, 0, 0)),
            // both lengths zero: trigger emits nothing, block stays idle
            cfg_row(CFG_PRE_LEN, 0),
            smp_row(100, 100, 0, mk_res(0, 0, 0)),
            // longest window per sample: full ring plus the trigger
            cfg_row(CFG_PRE_LEN, 32),
            cfg_row(CFG_POST_LEN, 1),
            smp_row(1, 1, 33, mk_res(0, 0, 0)),
            cfg_row(CFG_PRE_LEN, 0),
            cfg_row(CFG_POST_LEN, 4),
            cfg_row(CFG_THRESHOLD_SQ, 50),
            smp_row(7, 1, 0, mk_res(0, 0, 0)),
            smp_row(7, 2, 1, mk_res(7, 2, 0)),
            // loud sample inside a capture must not retrigger
            smp_row(32767, -32768, 1, mk_res(32767, -32768, 0)),
            // register change mid-capture: the running count is kept
            cfg_row(CFG_POST_LEN, 2),
            smp_row(3, 3, 1, mk_res(3, 3, 0)),
            smp_row(4, 4, 1, mk_res(4, 4, 1)),
            cfg_row(CFG_PRE_LEN, 3),
            smp_row(-32768, 0, 4, mk_res(32767, -32768, 0)),
            smp_row(0, -32768, 1, mk_res(0, -32768, 1)),
            cfg_row(CFG_THRESHOLD_SQ, 32'h8000_0000),
            cfg_row(CFG_POST_LEN, 16'hFFFF),
            smp_row(-32768, -32768, 0, mk_res(0, 0, 0))
        };

        // Hold reset at the start, then release it once for good.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table; settle once before each run of register writes.
        for (int r = 0; r < dir_tab.size(); r++) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                if (r == 0 || dir_tab[r-1].kind != ROW_CFG) settle();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                send_sample(dir_tab[r].smp, dir_tab[r].n_out, dir_tab[r].first);
            end
        end

        // Random phases: mostly quiet samples, with random loud samples that trigger.
        for (int p = 0; p < PHASE_N; p++) begin
            settle();
            case (p)
                0: begin
                    mode = IDLE_NONE;
                    write_reg(CFG_THRESHOLD_SQ, 10000);
                    write_reg(CFG_PRE_LEN, 4);
                    write_reg(CFG_POST_LEN, 3);
                end
                1: begin
                    mode = IDLE_TX;
                    write_reg(CFG_THRESHOLD_SQ, 5000);
                    write_reg(CFG_PRE_LEN, 32);
                    write_reg(CFG_POST_LEN, 1);
                end
                2: begin
                    mode = IDLE_RX;
                    write_reg(CFG_THRESHOLD_SQ, 20000);
                    write_reg(CFG_PRE_LEN, 63);
                    write_reg(CFG_POST_LEN, 5);
                end
                3: begin
                    mode = IDLE_BOTH;
                    write_reg(CFG_THRESHOLD_SQ, 0);
                    write_reg(CFG_PRE_LEN, 0);
                    write_reg(CFG_POST_LEN, 2);
                end
                4: begin
                    mode = IDLE_RX;
                    write_reg(CFG_THRESHOLD_SQ, $urandom & 32'h7FFF_FFFF);
                    write_reg(CFG_PRE_LEN, $urandom_range(63));
                    write_reg(CFG_POST_LEN, $urandom_range(6));
                end
                default: begin
                    mode = IDLE_NONE;
                    write_reg(CFG_THRESHOLD_SQ, 3000);
                    write_reg(CFG_PRE_LEN, $urandom_range(32));
                    write_reg(CFG_POST_LEN, $urandom_range(20, 1));
                end
            endcase
            tx_idle_pct  = (mode == IDLE_TX) ? 84 : (mode == IDLE_BOTH) ? 7 : 0;
            rx_stall_pct = (mode == IDLE_RX) ? 84 : (mode == IDLE_BOTH) ? 7 : 0;
            // Stall the receiver long enough for the block to back up its input.
            if (p == 2) hold_asks++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 20) begin
                    s = t_in_item'($urandom);
                end else begin
                    s = mk_smp(int'($urandom_range(80)) - 40,
                               int'($urandom_range(80)) - 40);
                end
                send_sample(s, -1, '0);
            end
        end

        settle();
        if (fault_cnt == 0 && capture_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== level_trigger_pretrigger_capture.f =====
design/ltpc_pkg.sv
design/ltpc_ram.sv
design/ltpc_ring.sv
design/level_trigger_pretrigger_capture.sv
tb/level_trigger_pretrigger_capture_test.sv
